// ----- design/abp_pkg.sv -----
// abp_pkg: shared types and codes for the ARGB alpha blend pixel unit.
// Used by every module in the design folder; depends on nothing.
package abp_pkg;

    localparam int CH_W   = 8;
    localparam int NUM_CH = 4;
    localparam int PROD_W = 18;

    localparam logic [CH_W-1:0] ALPHA_CLEAR = 8'hFF;
    localparam logic [CH_W-1:0] ALPHA_SOLID = 8'h00;

    // channel slots in a pixel word
    localparam int CH_A = 0;
    localparam int CH_R = 1;
    localparam int CH_G = 2;
    localparam int CH_B = 3;

    localparam logic [1:0] CMD_FILL  = 2'd0;
    localparam logic [1:0] CMD_COPY  = 2'd1;
    localparam logic [1:0] CMD_GLYPH = 2'd2;

    localparam logic [1:0] REG_DRAW_ALPHA = 2'd0;
    localparam logic [1:0] REG_DRAW_RED   = 2'd1;
    localparam logic [1:0] REG_DRAW_GREEN = 2'd2;
    localparam logic [1:0] REG_DRAW_BLUE  = 2'd3;

    typedef enum logic [2:0] {
        MODE_PASS  = 3'b001,
        MODE_BLEND = 3'b010,
        MODE_DRAW  = 3'b100
    } t_mode;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_pix;

    typedef struct packed {
        t_mode           mode;
        logic [CH_W-1:0] a;
        t_pix            s;
        t_pix            d;
    } t_s1;

    typedef struct packed {
        t_mode                  mode;
        t_pix                   s;
        t_pix                   d;
        logic [2:0][PROD_W-1:0] prod;
        logic [2*CH_W-1:0]      pa;
    } t_s2;

endpackage

// ----- design/abp_sel.sv -----
// abp_sel: drawing colour registers and command decode, first pipeline stage.
// Depends on abp_pkg.
module abp_sel
    import abp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [CH_W-1:0] i_cfg_data,
    input  logic            i_ld,
    input  logic            i_valid,
    input  logic [1:0]      i_cmd,
    input  t_pix            i_dst,
    input  t_pix            i_src,
    output logic            o_valid,
    output t_s1             o_st
);

    logic [CH_W-1:0] r_draw_a, r_draw_r, r_draw_g, r_draw_b;
    logic            r_valid;
    t_s1             r_st;
    t_s1             n_st;
    t_pix            w_draw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_a <= '0;
            r_draw_r <= '0;
            r_draw_g <= '0;
            r_draw_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DRAW_ALPHA: r_draw_a <= i_cfg_data;
                REG_DRAW_RED:   r_draw_r <= i_cfg_data;
                REG_DRAW_GREEN: r_draw_g <= i_cfg_data;
                REG_DRAW_BLUE:  r_draw_b <= i_cfg_data;
                default:        r_draw_a <= r_draw_a;
            endcase
        end
    end

    always_comb begin
        w_draw[CH_A] = r_draw_a;
        w_draw[CH_R] = r_draw_r;
        w_draw[CH_G] = r_draw_g;
        w_draw[CH_B] = r_draw_b;
        n_st.mode = MODE_PASS;
        n_st.a    = i_src[CH_A];
        n_st.s    = w_draw;
        n_st.d    = i_dst;
        case (i_cmd)
            CMD_FILL: begin
                n_st.a = r_draw_a;
                if (r_draw_a != ALPHA_CLEAR) n_st.mode = MODE_BLEND;
            end
            CMD_COPY: begin
                n_st.mode = MODE_BLEND;
                n_st.s    = i_src;
            end
            CMD_GLYPH: begin
                if (i_src[CH_A] == ALPHA_SOLID)      n_st.mode = MODE_DRAW;
                else if (i_src[CH_A] != ALPHA_CLEAR) n_st.mode = MODE_BLEND;
            end
            default: n_st.mode = MODE_PASS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

// ----- design/abp_mul.sv -----
// abp_mul: second stage, signed channel products and the alpha product.
// Depends on abp_pkg.
module abp_mul
    import abp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_ld,
    input  logic i_valid,
    input  t_s1  i_st,
    output logic o_valid,
    output t_s2  o_st
);

    logic              r_valid;
    t_s2               r_st;
    t_s2               n_st;
    logic signed [8:0] w_diff [3];
    logic signed [8:0] w_a;

    always_comb begin
        w_a       = $signed({1'b0, i_st.a});
        n_st.mode = i_st.mode;
        n_st.s    = i_st.s;
        n_st.d    = i_st.d;
        n_st.pa   = {{CH_W{1'b0}}, i_st.d[CH_A]} * {{CH_W{1'b0}}, i_st.a};
        for (int i = 0; i < 3; i++) begin
            w_diff[i]    = $signed({1'b0, i_st.d[i+1]}) - $signed({1'b0, i_st.s[i+1]});
            n_st.prod[i] = PROD_W'(w_diff[i]) * PROD_W'(w_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

// ----- design/abp_out.sv -----
// abp_out: third stage, truncating scale, offset and result select; output register.
// Depends on abp_pkg.
module abp_out
    import abp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ld,
    input  logic            i_valid,
    input  t_s2             i_st,
    output logic            o_valid,
    output t_pix            o_pix,
    output logic            o_written
);

    logic                     r_valid;
    t_pix                     r_pix;
    logic                     r_written;
    t_pix                     n_pix;
    logic                     n_written;
    logic signed [PROD_W-1:0] w_p   [3];
    logic signed [PROD_W-1:0] w_adj [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_p[i]   = $signed(i_st.prod[i]);
            // round toward zero on negative products
            w_adj[i] = w_p[i][PROD_W-1] ? (w_p[i] + 18'sd255) : w_p[i];
        end
        n_pix     = i_st.d;
        n_written = 1'b0;
        case (i_st.mode)
            MODE_BLEND: begin
                n_written   = 1'b1;
                n_pix[CH_A] = i_st.pa[2*CH_W-1:CH_W];
                for (int i = 0; i < 3; i++) begin
                    n_pix[i+1] = i_st.s[i+1] + w_adj[i][15:8];
                end
            end
            MODE_DRAW: begin
                n_written = 1'b1;
                n_pix     = i_st.s;
            end
            default: n_written = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_pix     <= n_pix;
            r_written <= n_written;
        end
    end

    assign o_valid   = r_valid;
    assign o_pix     = r_pix;
    assign o_written = r_written;

endmodule

// ----- design/argb_alpha_blend_pixel_unit.sv -----
// argb_alpha_blend_pixel_unit: top level of the ARGB pixel compositor.
// Depends on abp_pkg, abp_sel, abp_mul, abp_out.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | i_valid / o_stall  | i_cmd, i_dst_*, i_src_*
//  out     | o_valid / i_stall  | o_out_*, o_written
//  config  | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Three register stages (decode, multiply, scale/select).
// One item per cycle sustained while i_stall stays low.
// Synchronous active-low reset empties the pipeline and clears the colour registers.
// A stall holds the output; bubbles still collapse, so o_stall rises only when all
// three stages hold items.
module argb_alpha_blend_pixel_unit
    import abp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [CH_W-1:0] i_cfg_data,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_cmd,
    input  logic [CH_W-1:0] i_dst_alpha,
    input  logic [CH_W-1:0] i_dst_red,
    input  logic [CH_W-1:0] i_dst_green,
    input  logic [CH_W-1:0] i_dst_blue,
    input  logic [CH_W-1:0] i_src_alpha,
    input  logic [CH_W-1:0] i_src_red,
    input  logic [CH_W-1:0] i_src_green,
    input  logic [CH_W-1:0] i_src_blue,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [CH_W-1:0] o_out_alpha,
    output logic [CH_W-1:0] o_out_red,
    output logic [CH_W-1:0] o_out_green,
    output logic [CH_W-1:0] o_out_blue,
    output logic            o_written
);

    logic w_ld1, w_ld2, w_ld3;
    logic w_v1, w_v2;
    t_s1  w_s1;
    t_s2  w_s2;
    t_pix w_dst, w_src, w_pix;

    assign w_dst[CH_A] = i_dst_alpha;
    assign w_dst[CH_R] = i_dst_red;
    assign w_dst[CH_G] = i_dst_green;
    assign w_dst[CH_B] = i_dst_blue;
    assign w_src[CH_A] = i_src_alpha;
    assign w_src[CH_R] = i_src_red;
    assign w_src[CH_G] = i_src_green;
    assign w_src[CH_B] = i_src_blue;

    // a stage loads when empty or when its item moves on
    assign w_ld3   = !o_valid || !i_stall;
    assign w_ld2   = !w_v2 || w_ld3;
    assign w_ld1   = !w_v1 || w_ld2;
    assign o_stall = !w_ld1;

    abp_sel u_sel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ld       (w_ld1),
        .i_valid    (i_valid),
        .i_cmd      (i_cmd),
        .i_dst      (w_dst),
        .i_src      (w_src),
        .o_valid    (w_v1),
        .o_st       (w_s1)
    );

    abp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (w_ld2),
        .i_valid (w_v1),
        .i_st    (w_s1),
        .o_valid (w_v2),
        .o_st    (w_s2)
    );

    abp_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ld      (w_ld3),
        .i_valid   (w_v2),
        .i_st      (w_s2),
        .o_valid   (o_valid),
        .o_pix     (w_pix),
        .o_written (o_written)
    );

    assign o_out_alpha = w_pix[CH_A];
    assign o_out_red   = w_pix[CH_R];
    assign o_out_green = w_pix[CH_G];
    assign o_out_blue  = w_pix[CH_B];

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (w_v1 && w_v2 && o_valid))
        else $error("stall raised with a free stage");

    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("stall raised while output drains");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_v1)
        else $error("accepted item missing from first stage");

    a_advance_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v2 && w_ld3) |=> o_valid)
        else $error("item lost between multiply and output stage");

endmodule
